@@ hdl/rmq_pkg.sv @@
package rmq_pkg;

  // Field and datapath widths
  localparam int M_W       = 16;  // matrix entry, signed Q1.14
  localparam int Q_W       = 16;  // signed quaternion vector part
  localparam int ROOT_W    = 15;  // root magnitude, also the w field
  localparam int SUM_W     = 18;  // exact diagonal sum
  localparam int RAD_SHIFT = 12;  // radicand is sum * 2^12
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int REM_W     = ROOT_W + 3;
  localparam int Q_ONE     = 16384;

  // Root iterations done in one pipeline stage
  localparam int STEPS_DEFAULT = 3;

  // Lane order inside a stage
  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_Z = 2;
  localparam int LANE_W = 3;
  localparam int NLANE  = 4;
  localparam int NVEC   = 3;

  typedef struct packed {
    logic signed [M_W-1:0] m_00;
    logic signed [M_W-1:0] m_01;
    logic signed [M_W-1:0] m_02;
    logic signed [M_W-1:0] m_10;
    logic signed [M_W-1:0] m_11;
    logic signed [M_W-1:0] m_12;
    logic signed [M_W-1:0] m_20;
    logic signed [M_W-1:0] m_21;
    logic signed [M_W-1:0] m_22;
  } in_t;

  typedef struct packed {
    logic signed [Q_W-1:0] quat_x;
    logic signed [Q_W-1:0] quat_y;
    logic signed [Q_W-1:0] quat_z;
    logic [ROOT_W-1:0]     quat_w;
  } out_t;

  // One square root in flight: remaining radicand digits, partial remainder, partial root
  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } lane_t;

  typedef struct packed {
    lane_t [NLANE-1:0] lane;
    logic [NVEC-1:0]   neg;  // vector part takes the negative sign
  } stage_t;

  // One restoring square root iteration: bring down two radicand bits, try root*4+1
  function automatic lane_t root_step(lane_t l);
    lane_t            o;
    logic [REM_W-1:0] acc;
    logic [REM_W-1:0] trial;
    acc   = {l.rem[REM_W-3:0], l.rad[RAD_W-1 -: 2]};
    trial = {{(REM_W-ROOT_W-2){1'b0}}, l.root, 2'b01};
    o.rad = {l.rad[RAD_W-3:0], 2'b00};
    if (acc >= trial) begin
      o.rem  = acc - trial;
      o.root = {l.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = acc;
      o.root = {l.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

@@ hdl/rmq_prep.sv @@
module rmq_prep (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  rmq_pkg::in_t    in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output rmq_pkg::stage_t out_data
);

  logic            v_r;
  rmq_pkg::stage_t data_r;
  rmq_pkg::stage_t data_nxt;

  // Clamp a signed sum at zero and scale it into the radicand
  function automatic logic [rmq_pkg::RAD_W-1:0] to_rad(logic signed [rmq_pkg::SUM_W-1:0] s);
    if (s <= 0) begin
      return '0;
    end
    return {{(rmq_pkg::RAD_W-rmq_pkg::SUM_W+1-rmq_pkg::RAD_SHIFT){1'b0}},
            s[rmq_pkg::SUM_W-2:0], {rmq_pkg::RAD_SHIFT{1'b0}}};
  endfunction

  logic signed [rmq_pkg::SUM_W-1:0] one;
  logic signed [rmq_pkg::SUM_W-1:0] d0;
  logic signed [rmq_pkg::SUM_W-1:0] d1;
  logic signed [rmq_pkg::SUM_W-1:0] d2;
  logic signed [rmq_pkg::M_W:0]     dx;
  logic signed [rmq_pkg::M_W:0]     dy;
  logic signed [rmq_pkg::M_W:0]     dz;

  // Form the four diagonal sums and the three sign differences
  always_comb begin
    one = rmq_pkg::SUM_W'(rmq_pkg::Q_ONE);
    d0  = rmq_pkg::SUM_W'(in_data.m_00);
    d1  = rmq_pkg::SUM_W'(in_data.m_11);
    d2  = rmq_pkg::SUM_W'(in_data.m_22);
    dx  = (rmq_pkg::M_W+1)'(in_data.m_21) - (rmq_pkg::M_W+1)'(in_data.m_12);
    dy  = (rmq_pkg::M_W+1)'(in_data.m_02) - (rmq_pkg::M_W+1)'(in_data.m_20);
    dz  = (rmq_pkg::M_W+1)'(in_data.m_10) - (rmq_pkg::M_W+1)'(in_data.m_01);

    data_nxt = '0;
    data_nxt.lane[rmq_pkg::LANE_W].rad = to_rad(one + d0 + d1 + d2);
    data_nxt.lane[rmq_pkg::LANE_X].rad = to_rad(one + d0 - d1 - d2);
    data_nxt.lane[rmq_pkg::LANE_Y].rad = to_rad(one - d0 + d1 - d2);
    data_nxt.lane[rmq_pkg::LANE_Z].rad = to_rad(one - d0 - d1 + d2);
    data_nxt.neg[rmq_pkg::LANE_X] = dx[rmq_pkg::M_W];
    data_nxt.neg[rmq_pkg::LANE_Y] = dy[rmq_pkg::M_W];
    data_nxt.neg[rmq_pkg::LANE_Z] = dz[rmq_pkg::M_W];
  end

  assign in_ready = !v_r || out_ready;

  // Advance the stage whenever the next one takes the item or this one is empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data  = data_r;

endmodule

@@ hdl/rmq_root_stage.sv @@
module rmq_root_stage #(
  parameter int FIRST_IDX = 0,
  parameter int STEPS     = rmq_pkg::STEPS_DEFAULT
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  rmq_pkg::stage_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output rmq_pkg::stage_t out_data
);

  logic            v_r;
  rmq_pkg::stage_t data_r;
  rmq_pkg::stage_t data_nxt;

  // Run this stage's share of root iterations on all four lanes
  always_comb begin
    data_nxt = in_data;
    for (int l = 0; l < rmq_pkg::NLANE; l++) begin
      for (int j = 0; j < STEPS; j++) begin
        if (FIRST_IDX + j < rmq_pkg::ROOT_W) begin
          data_nxt.lane[l] = rmq_pkg::root_step(data_nxt.lane[l]);
        end
      end
    end
  end

  assign in_ready = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data  = data_r;

endmodule

@@ hdl/rmq_pack.sv @@
module rmq_pack (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  rmq_pkg::stage_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output rmq_pkg::out_t   out_data
);

  logic          v_r;
  rmq_pkg::out_t data_r;
  rmq_pkg::out_t data_nxt;

  // Apply the sign to a root magnitude
  function automatic logic [rmq_pkg::Q_W-1:0] apply_sign(logic [rmq_pkg::ROOT_W-1:0] mag,
                                                         logic neg);
    logic [rmq_pkg::Q_W-1:0] m;
    m = {{(rmq_pkg::Q_W-rmq_pkg::ROOT_W){1'b0}}, mag};
    return neg ? (~m + 1'b1) : m;
  endfunction

  always_comb begin
    data_nxt.quat_x = apply_sign(in_data.lane[rmq_pkg::LANE_X].root,
                                 in_data.neg[rmq_pkg::LANE_X]);
    data_nxt.quat_y = apply_sign(in_data.lane[rmq_pkg::LANE_Y].root,
                                 in_data.neg[rmq_pkg::LANE_Y]);
    data_nxt.quat_z = apply_sign(in_data.lane[rmq_pkg::LANE_Z].root,
                                 in_data.neg[rmq_pkg::LANE_Z]);
    data_nxt.quat_w = in_data.lane[rmq_pkg::LANE_W].root;
  end

  assign in_ready = !v_r || out_ready;

  // Output register: hold the item until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data  = data_r;

endmodule

@@ hdl/rotation_matrix_to_quaternion.sv @@
// Rotation matrix to unit quaternion, signed Q1.14 fixed point.
// Input channel in_valid / in_ready / in_data carries one 3x3 matrix per item;
// the output channel out_valid / out_ready / out_data carries the quaternion
// (x, y, z, w) for it, one result item for every input item, in order.
// Each magnitude is the truncated half square root of a clamped diagonal sum;
// x, y, z take the sign of their off-diagonal difference, zero giving positive.
// Throughput: one item per cycle while out_ready is high. Items pass through
// the prep register, the root stages and the pack register in turn. The 15
// restoring root iterations are spread over the root stages, at most STEPS per
// stage (three by default), and run on four lanes side by side.
// Every stage is an elastic register with its own valid bit. When the receiver
// stalls, the pipeline fills up and in_ready drops only once every stage holds
// an item; nothing is dropped or repeated. With out_ready high, in_ready is high.
// Synchronous reset (rst_n low) empties the pipeline; items in flight are lost.
module rotation_matrix_to_quaternion #(
  parameter int STEPS = rmq_pkg::STEPS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rmq_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output rmq_pkg::out_t out_data
);

  localparam int NSTG = (rmq_pkg::ROOT_W + STEPS - 1) / STEPS;

  logic            st_valid [NSTG+1];
  logic            st_ready [NSTG+1];
  rmq_pkg::stage_t st_data  [NSTG+1];

  // Diagonal sums, clamp and sign differences
  rmq_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (st_valid[0]),
    .out_ready (st_ready[0]),
    .out_data  (st_data[0])
  );

  // Square root stages
  for (genvar k = 1; k <= NSTG; k++) begin : g_root
    rmq_root_stage #(
      .FIRST_IDX ((k - 1) * STEPS),
      .STEPS     (STEPS)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (st_valid[k-1]),
      .in_ready  (st_ready[k-1]),
      .in_data   (st_data[k-1]),
      .out_valid (st_valid[k]),
      .out_ready (st_ready[k]),
      .out_data  (st_data[k])
    );
  end

  // Sign application and output register
  rmq_pack u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (st_valid[NSTG]),
    .in_ready  (st_ready[NSTG]),
    .in_data   (st_data[NSTG]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ hdl/rmq_checker.sv @@
module rmq_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input rmq_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input rmq_pkg::out_t out_data
);

  localparam int MAG_MAX = 21675;

  // A stalled input item holds its payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input item changed while stalled");

  // A stalled result item holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item valid after reset");

  // A receiver that is ready never backs up the input
  a_no_bubble_stall: assert property (@(posedge clk)
    out_ready |-> in_ready)
    else $error("input stalled while receiver ready");

  // Magnitudes stay within the largest half root
  a_mag_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_data.quat_w) <= MAG_MAX) &&
                  (int'(out_data.quat_x) <= MAG_MAX) && (int'(out_data.quat_x) >= -MAG_MAX) &&
                  (int'(out_data.quat_y) <= MAG_MAX) && (int'(out_data.quat_y) >= -MAG_MAX) &&
                  (int'(out_data.quat_z) <= MAG_MAX) && (int'(out_data.quat_z) >= -MAG_MAX))
    else $error("quaternion component out of range");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
